[rtl/tcce_pkg.sv]
// Shared types and constants for the text console cell engine.
// Request codes, character codes, cell walker command/status structs.
// No dependencies.
package tcce_pkg;

  // Request codes on req_type
  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_SET   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  // Character codes with special handling
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  // Register map (byte addresses)
  localparam logic [2:0] ADDR_NARROW_MODE = 3'd0;

  // Widths that cover the whole row/column range of the engine
  localparam int unsigned WalkRowW = 6;
  localparam int unsigned WalkColW = 7;

  // Rectangle of cells for the walker to visit, row-major
  typedef struct packed {
    logic [WalkRowW-1:0] row_first;
    logic [WalkColW-1:0] col_first;
    logic [WalkRowW-1:0] row_last;
    logic [WalkColW-1:0] col_last;
  } walk_cmd_t;

  // Walker status: an address is presented, and it is the final one
  typedef struct packed {
    logic valid;
    logic last;
  } walk_sts_t;

endpackage

[rtl/tcce_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tcce_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/tcce_walker.sv]
// Cell address walker: visits a rectangle of the cell store row by row,
// one address per cycle, using one shared row-base accumulator.
// Depends on tcce_pkg.
module tcce_walker
  import tcce_pkg::*;
#(
  parameter int unsigned TEXT_COLS = 80,
  parameter int unsigned ADDR_W    = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  walk_cmd_t         cmd_i,
  output walk_sts_t         sts_o,
  output logic [ADDR_W-1:0] addr_o
);

  logic              busy_q;
  walk_cmd_t         cmd_q;
  logic [WalkRowW-1:0] row_q;
  logic [WalkColW-1:0] col_q;
  logic [ADDR_W-1:0] base_q;
  logic              at_last;
  logic              at_row_end;

  assign at_row_end = (col_q == cmd_q.col_last);
  assign at_last    = at_row_end && (row_q == cmd_q.row_last);

  // Walk state: a new command takes priority over the one finishing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cmd_q  <= '0;
      row_q  <= '0;
      col_q  <= '0;
      base_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cmd_q  <= cmd_i;
      row_q  <= cmd_i.row_first;
      col_q  <= cmd_i.col_first;
      base_q <= ADDR_W'(32'(cmd_i.row_first) * TEXT_COLS);
    end else if (busy_q) begin
      if (at_last) begin
        busy_q <= 1'b0;
      end else if (at_row_end) begin
        col_q  <= cmd_q.col_first;
        row_q  <= row_q + 1'b1;
        base_q <= base_q + ADDR_W'(TEXT_COLS);
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  assign addr_o      = base_q + ADDR_W'(col_q);
  assign sts_o.valid = busy_q;
  assign sts_o.last  = busy_q && at_last;

endmodule

[rtl/text_console_cell_engine_core.sv]
// Text console cell engine, top level: sequencer, cursor, config register.
// The walker steps one cell address per cycle for writes, reads, scroll copies and
// clears. One transaction at a time, the next accepted the cycle after the result
// registers. Reset: cursor home, narrow_mode 0, then a clearing pass over every cell
// of the store before input is accepted.
module text_console_cell_engine_core
  import tcce_pkg::*;
#(
  parameter int unsigned TEXT_COLS   = 80,
  parameter int unsigned TEXT_ROWS   = 25,
  parameter int unsigned NARROW_COLS = 40,
  parameter int unsigned NARROW_ROWS = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  char_code_i,
  input  logic [7:0]  target_row_i,
  input  logic [7:0]  target_col_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  cur_row_o,
  output logic [6:0]  cur_col_o,
  output logic [7:0]  cell_value_o,
  output logic        did_scroll_o
);

  localparam int unsigned Depth   = TEXT_COLS * TEXT_ROWS;
  localparam int unsigned AddrW   = $clog2(Depth);
  localparam int unsigned RowW    = $clog2(TEXT_ROWS);
  localparam int unsigned ColW    = $clog2(TEXT_COLS);
  localparam int unsigned VisRowsN = (NARROW_ROWS > TEXT_ROWS) ? TEXT_ROWS : NARROW_ROWS;
  localparam int unsigned VisColsN = (NARROW_COLS > TEXT_COLS) ? TEXT_COLS : NARROW_COLS;
  localparam logic [RowW-1:0] LastRowT = RowW'(TEXT_ROWS - 1);
  localparam logic [RowW-1:0] LastRowN = RowW'(VisRowsN - 1);
  localparam logic [ColW-1:0] LastColT = ColW'(TEXT_COLS - 1);
  localparam logic [ColW-1:0] LastColN = ColW'(VisColsN - 1);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_WRITE,
    S_READ,
    S_READ_WAIT,
    S_COPY,
    S_COPY_TAIL,
    S_BLANK,
    S_CLEAR,
    S_DONE
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic narrow_q;
  logic cfg_wr;

  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_NARROW_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      narrow_q <= 1'b0;
    end else if (cfg_wr) begin
      narrow_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_NARROW_MODE) ? {31'd0, narrow_q} : 32'd0;

  // Visible area limits for the current layout
  logic [RowW-1:0] last_row;
  logic [ColW-1:0] last_col;

  assign last_row = narrow_q ? LastRowN : LastRowT;
  assign last_col = narrow_q ? LastColN : LastColT;

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  state_e          state_q;
  req_e            req_q;
  logic [7:0]      ch_q;
  logic [RowW-1:0] row_q;
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] trow_q;
  logic [ColW-1:0] tcol_q;
  logic            scroll_q;
  logic [7:0]      value_q;
  logic            pend_q;
  logic [AddrW-1:0] dst_q;
  logic            out_valid_q;
  logic [4:0]      out_row_q;
  logic [6:0]      out_col_q;
  logic [7:0]      out_value_q;
  logic            out_scroll_q;
  logic            init_kick_q;

  // Walker and RAM hookup
  logic             walk_start;
  walk_cmd_t        walk_cmd;
  walk_sts_t        walk_sts;
  logic [AddrW-1:0] walk_addr;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [7:0]       ram_rdata;

  tcce_walker #(
    .TEXT_COLS(TEXT_COLS),
    .ADDR_W   (AddrW)
  ) u_walker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(walk_start),
    .cmd_i  (walk_cmd),
    .sts_o  (walk_sts),
    .addr_o (walk_addr)
  );

  tcce_ram #(
    .WIDTH(8),
    .DEPTH(Depth)
  ) u_cells (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(walk_addr),
    .rdata_o(ram_rdata)
  );

  // Clamped values captured at transaction accept
  logic            in_fire;
  logic [RowW-1:0] row_clamped;
  logic [ColW-1:0] col_clamped;
  logic [RowW-1:0] trow_clamped;
  logic [ColW-1:0] tcol_clamped;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  assign row_clamped  = (row_q > last_row) ? last_row : row_q;
  assign col_clamped  = (col_q > last_col) ? last_col : col_q;
  assign trow_clamped = (target_row_i > 8'(last_row)) ? last_row : target_row_i[RowW-1:0];
  assign tcol_clamped = (target_col_i > 8'(last_col)) ? last_col : target_col_i[ColW-1:0];

  // Walker commands: single cell, full store, scroll copy, last-row blank
  walk_cmd_t cmd_cursor;
  walk_cmd_t cmd_target;
  walk_cmd_t cmd_backsp;
  walk_cmd_t cmd_all;
  walk_cmd_t cmd_copy;
  walk_cmd_t cmd_blank;

  always_comb begin
    cmd_cursor = '{row_first: WalkRowW'(row_q), col_first: WalkColW'(col_q),
                   row_last:  WalkRowW'(row_q), col_last:  WalkColW'(col_q)};
    cmd_backsp = '{row_first: WalkRowW'(row_q), col_first: WalkColW'(col_q - 1'b1),
                   row_last:  WalkRowW'(row_q), col_last:  WalkColW'(col_q - 1'b1)};
    cmd_target = '{row_first: WalkRowW'(trow_q), col_first: WalkColW'(tcol_q),
                   row_last:  WalkRowW'(trow_q), col_last:  WalkColW'(tcol_q)};
    cmd_all    = '{row_first: '0, col_first: '0,
                   row_last:  WalkRowW'(TEXT_ROWS - 1), col_last: WalkColW'(TEXT_COLS - 1)};
    cmd_copy   = '{row_first: WalkRowW'(1), col_first: '0,
                   row_last:  WalkRowW'(last_row), col_last: WalkColW'(last_col)};
    cmd_blank  = '{row_first: WalkRowW'(last_row), col_first: '0,
                   row_last:  WalkRowW'(last_row), col_last: WalkColW'(last_col)};
  end

  // Walker start and RAM port control per state
  always_comb begin
    walk_start = 1'b0;
    walk_cmd   = cmd_cursor;
    ram_we     = 1'b0;
    ram_waddr  = walk_addr;
    ram_wdata  = CH_SPACE;
    ram_re     = 1'b0;
    unique case (state_q)
      S_INIT: begin
        ram_we     = walk_sts.valid;
        walk_start = init_kick_q;
        walk_cmd   = cmd_all;
      end
      S_CLEAR, S_BLANK: begin
        ram_we = walk_sts.valid;
      end
      S_EXEC: begin
        unique case (req_q)
          REQ_PUT: begin
            if (ch_q == CH_NEWLINE) begin
              walk_start = (row_q == last_row);
              walk_cmd   = cmd_copy;
            end else if (ch_q == CH_BACKSPACE) begin
              walk_start = (col_q != '0);
              walk_cmd   = cmd_backsp;
            end else begin
              walk_start = 1'b1;
              walk_cmd   = cmd_cursor;
            end
          end
          REQ_CLEAR: begin
            walk_start = 1'b1;
            walk_cmd   = cmd_all;
          end
          REQ_READ: begin
            walk_start = 1'b1;
            walk_cmd   = cmd_target;
          end
          default: begin
            walk_start = 1'b0;
          end
        endcase
      end
      S_WRITE: begin
        ram_we     = walk_sts.valid;
        ram_wdata  = (ch_q == CH_BACKSPACE) ? CH_SPACE : ch_q;
        walk_start = scroll_q;
        walk_cmd   = cmd_copy;
      end
      S_READ: begin
        ram_re = walk_sts.valid;
      end
      S_COPY: begin
        ram_re    = walk_sts.valid;
        ram_we    = pend_q;
        ram_waddr = dst_q;
        ram_wdata = ram_rdata;
      end
      S_COPY_TAIL: begin
        ram_we     = pend_q;
        ram_waddr  = dst_q;
        ram_wdata  = ram_rdata;
        walk_start = 1'b1;
        walk_cmd   = cmd_blank;
      end
      default: begin
        walk_start = 1'b0;
      end
    endcase
  end

  // Sequencer, cursor and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      req_q        <= REQ_PUT;
      ch_q         <= '0;
      row_q        <= '0;
      col_q        <= '0;
      trow_q       <= '0;
      tcol_q       <= '0;
      scroll_q     <= 1'b0;
      value_q      <= '0;
      pend_q       <= 1'b0;
      dst_q        <= '0;
      out_valid_q  <= 1'b0;
      out_row_q    <= '0;
      out_col_q    <= '0;
      out_value_q  <= '0;
      out_scroll_q <= 1'b0;
    end else begin
      // S_DONE handles the result register itself
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      pend_q <= (state_q == S_COPY) && walk_sts.valid;
      dst_q  <= walk_addr - AddrW'(TEXT_COLS);

      unique case (state_q)
        S_INIT: begin
          if (walk_sts.last) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            req_q    <= req_e'(req_type_i);
            ch_q     <= char_code_i;
            trow_q   <= trow_clamped;
            tcol_q   <= tcol_clamped;
            row_q    <= row_clamped;
            col_q    <= col_clamped;
            scroll_q <= 1'b0;
            value_q  <= '0;
            state_q  <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (req_q)
            REQ_PUT: begin
              if (ch_q == CH_NEWLINE) begin
                col_q <= '0;
                if (row_q == last_row) begin
                  scroll_q <= 1'b1;
                  state_q  <= S_COPY;
                end else begin
                  row_q   <= row_q + 1'b1;
                  state_q <= S_DONE;
                end
              end else if (ch_q == CH_BACKSPACE) begin
                if (col_q != '0) begin
                  col_q   <= col_q - 1'b1;
                  state_q <= S_WRITE;
                end else begin
                  state_q <= S_DONE;
                end
              end else begin
                state_q <= S_WRITE;
                if (col_q == last_col) begin
                  col_q <= '0;
                  if (row_q == last_row) begin
                    scroll_q <= 1'b1;
                  end else begin
                    row_q <= row_q + 1'b1;
                  end
                end else begin
                  col_q <= col_q + 1'b1;
                end
              end
            end
            REQ_SET: begin
              row_q   <= trow_q;
              col_q   <= tcol_q;
              state_q <= S_DONE;
            end
            REQ_CLEAR: begin
              row_q   <= '0;
              col_q   <= '0;
              state_q <= S_CLEAR;
            end
            REQ_READ: begin
              state_q <= S_READ;
            end
            default: begin
              state_q <= S_DONE;
            end
          endcase
        end
        S_WRITE: begin
          state_q <= scroll_q ? S_COPY : S_DONE;
        end
        S_READ: begin
          state_q <= S_READ_WAIT;
        end
        S_READ_WAIT: begin
          value_q <= ram_rdata;
          state_q <= S_DONE;
        end
        S_COPY: begin
          if (walk_sts.last) begin
            state_q <= S_COPY_TAIL;
          end
        end
        S_COPY_TAIL: begin
          state_q <= S_BLANK;
        end
        S_BLANK, S_CLEAR: begin
          if (walk_sts.last) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_row_q    <= 5'(row_q);
            out_col_q    <= 7'(col_q);
            out_value_q  <= value_q;
            out_scroll_q <= scroll_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cur_row_o    = out_row_q;
  assign cur_col_o    = out_col_q;
  assign cell_value_o = out_value_q;
  assign did_scroll_o = out_scroll_q;

  // Kick off the clearing pass right after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_kick_q <= 1'b1;
    end else begin
      init_kick_q <= 1'b0;
    end
  end

endmodule

[sim/text_console_cell_engine_core_tb.sv]
`timescale 1ns / 1ps
// Testbench for text_console_cell_engine_core: directed and random console requests,
// checked against an in-bench shadow of the cell store and cursor.
// Depends on tcce_pkg and the core RTL only.
module text_console_cell_engine_core_tb;
  import tcce_pkg::*;

  localparam int unsigned TEXT_COLS   = 80;
  localparam int unsigned TEXT_ROWS   = 25;
  localparam int unsigned NARROW_COLS = 40;
  localparam int unsigned NARROW_ROWS = 25;
  localparam int unsigned CELLS       = TEXT_COLS * TEXT_ROWS;

  localparam int unsigned RAND_PER_PHASE = 310;
  localparam int unsigned HOLD_AT        = 100;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned CALM_FIRST     = 700;
  localparam int unsigned CALM_LAST      = 900;
  localparam int unsigned MAX_PRINTED    = 40;

  typedef struct packed {
    req_e       kind;
    logic [7:0] ch;
    logic [7:0] row;
    logic [7:0] col;
  } console_req_t;

  typedef struct packed {
    logic [4:0] row;
    logic [6:0] col;
    logic [7:0] value;
    logic       scroll;
  } console_result_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [2:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [1:0]  req_type_i   = '0;
  logic [7:0]  char_code_i  = '0;
  logic [7:0]  target_row_i = '0;
  logic [7:0]  target_col_i = '0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [4:0]  cur_row_o;
  logic [6:0]  cur_col_o;
  logic [7:0]  cell_value_o;
  logic        did_scroll_o;

  // Shadow of the console state
  logic [7:0]  shadow_cells [CELLS] = '{default: CH_SPACE};
  int unsigned shadow_row    = 0;
  int unsigned shadow_col    = 0;
  logic        shadow_narrow = 1'b0;

  console_req_t    pending_reqs[$];
  console_result_t expected_results[$];
  console_req_t    next_req;
  console_result_t exp_res;
  int unsigned     n_accepted = 0;
  int unsigned     err_count  = 0;
  int unsigned     hold_left  = 0;
  logic            hold_done  = 1'b0;

  text_console_cell_engine_core #(
    .TEXT_COLS  (TEXT_COLS),
    .TEXT_ROWS  (TEXT_ROWS),
    .NARROW_COLS(NARROW_COLS),
    .NARROW_ROWS(NARROW_ROWS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .char_code_i (char_code_i),
    .target_row_i(target_row_i),
    .target_col_i(target_col_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cur_row_o   (cur_row_o),
    .cur_col_o   (cur_col_o),
    .cell_value_o(cell_value_o),
    .did_scroll_o(did_scroll_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(string what);
    err_count++;
    if (err_count <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // No random idling on either side while this window of transactions goes by
  function automatic logic calm_window();
    return n_accepted >= CALM_FIRST && n_accepted < CALM_LAST;
  endfunction

  function automatic int unsigned shown_cols();
    int unsigned c;
    c = shadow_narrow ? NARROW_COLS : TEXT_COLS;
    return (c > TEXT_COLS) ? TEXT_COLS : c;
  endfunction

  function automatic int unsigned shown_rows();
    int unsigned r;
    r = shadow_narrow ? NARROW_ROWS : TEXT_ROWS;
    return (r > TEXT_ROWS) ? TEXT_ROWS : r;
  endfunction

  // Next line; past the bottom the visible columns move up one row. Returns 1 on scroll.
  function automatic logic advance_line();
    int unsigned rows;
    int unsigned cols;
    rows = shown_rows();
    cols = shown_cols();
    shadow_col = 0;
    shadow_row++;
    if (shadow_row < rows) return 1'b0;
    for (int unsigned r = 1; r < rows; r++)
      for (int unsigned c = 0; c < cols; c++)
        shadow_cells[(r - 1) * TEXT_COLS + c] = shadow_cells[r * TEXT_COLS + c];
    for (int unsigned c = 0; c < cols; c++)
      shadow_cells[(rows - 1) * TEXT_COLS + c] = CH_SPACE;
    shadow_row = rows - 1;
    return 1'b1;
  endfunction

  // Apply one request to the shadow state and return the result it should produce
  function automatic console_result_t console_step(req_e kind, logic [7:0] ch,
                                                   logic [7:0] trow, logic [7:0] tcol);
    console_result_t res;
    int unsigned     rows;
    int unsigned     cols;
    int unsigned     row_sel;
    int unsigned     col_sel;
    rows = shown_rows();
    cols = shown_cols();
    res  = '0;
    // cursor is clamped first, so a mode change lands on the next request
    if (shadow_row >= rows) shadow_row = rows - 1;
    if (shadow_col >= cols) shadow_col = cols - 1;
    row_sel = (trow >= rows) ? rows - 1 : trow;
    col_sel = (tcol >= cols) ? cols - 1 : tcol;
    case (kind)
      REQ_PUT: begin
        if (ch == CH_NEWLINE) begin
          res.scroll = advance_line();
        end else if (ch == CH_BACKSPACE) begin
          // at column zero backspace does nothing
          if (shadow_col > 0) begin
            shadow_col--;
            shadow_cells[shadow_row * TEXT_COLS + shadow_col] = CH_SPACE;
          end
        end else begin
          shadow_cells[shadow_row * TEXT_COLS + shadow_col] = ch;
          shadow_col++;
          if (shadow_col >= cols) res.scroll = advance_line();
        end
      end
      REQ_SET: begin
        shadow_row = row_sel;
        shadow_col = col_sel;
      end
      REQ_CLEAR: begin
        foreach (shadow_cells[i]) shadow_cells[i] = CH_SPACE;
        shadow_row = 0;
        shadow_col = 0;
      end
      default: begin
        res.value = shadow_cells[row_sel * TEXT_COLS + col_sel];
      end
    endcase
    res.row = shadow_row[4:0];
    res.col = shadow_col[6:0];
    return res;
  endfunction

  function automatic void queue_req(req_e kind, logic [7:0] ch, logic [7:0] trow,
                                    logic [7:0] tcol);
    pending_reqs.push_back('{kind: kind, ch: ch, row: trow, col: tcol});
  endfunction

  // Mostly typing with newlines and backspaces, plus cursor moves, reads, rare clears
  function automatic void queue_random_req();
    int unsigned pick;
    logic [7:0]  ch;
    logic [7:0]  trow;
    logic [7:0]  tcol;
    pick = $urandom_range(999);
    ch   = 8'($urandom_range(255));
    trow = 8'($urandom_range(255));
    tcol = 8'($urandom_range(255));
    if (pick < 5) begin
      queue_req(REQ_CLEAR, ch, trow, tcol);
    end else if (pick < 145) begin
      if ($urandom_range(1) == 1) begin
        trow = 8'($urandom_range(TEXT_ROWS - 1));
        tcol = 8'($urandom_range(TEXT_COLS - 1));
      end
      queue_req((pick < 85) ? REQ_READ : REQ_SET, ch, trow, tcol);
    end else if (pick < 225) begin
      queue_req(REQ_PUT, CH_NEWLINE, trow, tcol);
    end else if (pick < 275) begin
      queue_req(REQ_PUT, CH_BACKSPACE, trow, tcol);
    end else if (pick < 375) begin
      queue_req(REQ_PUT, ch, trow, tcol);
    end else begin
      queue_req(REQ_PUT, 8'($urandom_range(126, 32)), trow, tcol);
    end
  endfunction

  // APB write of narrow_mode, then read it back
  task automatic config_write(logic mode);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_NARROW_MODE;
    pwdata  <= {31'd0, mode};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    shadow_narrow = mode;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata[0] !== mode)
      report_mismatch($sformatf("narrow_mode reads %0b, expected %0b", prdata[0], mode));
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || expected_results.size() != 0);
  endtask

  // Request driver: predicts each accepted transaction, then offers the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      req_type_i   <= REQ_PUT;
      char_code_i  <= '0;
      target_row_i <= '0;
      target_col_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(console_step(req_e'(req_type_i), char_code_i,
                                                target_row_i, target_col_i));
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_reqs.size() != 0 && (calm_window() || $urandom_range(99) >= 8)) begin
          next_req = pending_reqs.pop_front();
          in_valid_i   <= 1'b1;
          req_type_i   <= next_req.kind;
          char_code_i  <= next_req.ch;
          target_row_i <= next_req.row;
          target_col_i <= next_req.col;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor and ready control, with one long hold-off to back up the input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transaction with no request outstanding");
        end else begin
          exp_res = expected_results.pop_front();
          if (cur_row_o !== exp_res.row)
            report_mismatch($sformatf("cur_row %0d, expected %0d", cur_row_o, exp_res.row));
          if (cur_col_o !== exp_res.col)
            report_mismatch($sformatf("cur_col %0d, expected %0d", cur_col_o, exp_res.col));
          if (cell_value_o !== exp_res.value)
            report_mismatch($sformatf("cell_value %02h, expected %02h",
                                      cell_value_o, exp_res.value));
          if (did_scroll_o !== exp_res.scroll)
            report_mismatch($sformatf("did_scroll %0b, expected %0b",
                                      did_scroll_o, exp_res.scroll));
        end
      end
      if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (!hold_done && n_accepted >= HOLD_AT) begin
        hold_done   <= 1'b1;
        hold_left   <= HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm_window() || ($urandom_range(99) >= 8);
      end
    end
  end

  // Stimulus sequence
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    config_write(1'b0);

    // wide layout: edge bytes, backspace, saturation, wrap and newline scrolls, clear
    queue_req(REQ_READ, 8'h00, 8'd0, 8'd0);
    queue_req(REQ_PUT, 8'h41, 8'd0, 8'd0);
    queue_req(REQ_PUT, 8'hFF, 8'd0, 8'd0);
    queue_req(REQ_PUT, 8'h00, 8'd0, 8'd0);
    queue_req(REQ_PUT, CH_BACKSPACE, 8'd0, 8'd0);
    queue_req(REQ_READ, 8'h00, 8'd0, 8'd1);
    queue_req(REQ_SET, 8'h00, 8'd0, 8'd0);
    queue_req(REQ_PUT, CH_BACKSPACE, 8'd0, 8'd0);
    queue_req(REQ_SET, 8'h00, 8'd255, 8'd255);
    queue_req(REQ_PUT, 8'h5A, 8'd0, 8'd0);
    queue_req(REQ_READ, 8'h00, 8'd23, 8'd79);
    queue_req(REQ_PUT, CH_NEWLINE, 8'd0, 8'd0);
    queue_req(REQ_SET, 8'h00, 8'd3, 8'd200);
    queue_req(REQ_PUT, CH_NEWLINE, 8'd0, 8'd0);
    queue_req(REQ_CLEAR, 8'h00, 8'd0, 8'd0);
    queue_req(REQ_READ, 8'h00, 8'd22, 8'd79);
    queue_req(REQ_SET, 8'h00, 8'd5, 8'd70);

    for (int p = 0; p < 4; p++) begin
      wait_idle();
      config_write((p % 2) == 0);
      if (p == 0) begin
        // narrow layout: cursor clamped at request start, narrow wrap and scroll
        queue_req(REQ_PUT, 8'h71, 8'd0, 8'd0);
        queue_req(REQ_READ, 8'h00, 8'd5, 8'd200);
        queue_req(REQ_SET, 8'h00, 8'd255, 8'd255);
        queue_req(REQ_PUT, 8'h77, 8'd0, 8'd0);
        queue_req(REQ_READ, 8'h00, 8'd23, 8'd39);
      end
      repeat (RAND_PER_PHASE) queue_random_req();
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
